// ===== src/gae_pkg.sv =====
`default_nettype none

package gae_pkg;

    // Operation codes carried in the op field of an input beat.
    localparam logic [2:0] OP_LOAD_POS  = 3'd0;
    localparam logic [2:0] OP_LOAD_VEL  = 3'd1;
    localparam logic [2:0] OP_CLEAR_ACC = 3'd2;
    localparam logic [2:0] OP_ACCUM     = 3'd3;
    localparam logic [2:0] OP_INTEGRATE = 3'd4;

    // Signed Q16.16 word limits, held at the width of the saturating adders.
    localparam logic signed [35:0] W_MAX = 36'sd2147483647;
    localparam logic signed [35:0] W_MIN = -36'sd2147483648;

    // 1e-6 in Q.30 units, added to the squared distance.
    localparam logic [63:0] EPS_Q30 = 64'd1074;

    // Shared divider: 76-bit dividend, 64-bit divisor, one quotient bit a cycle.
    localparam int DIV_NW = 76;
    localparam int DIV_DW = 64;

    // Gravity constant reset value, 1.0 in Q16.16.
    localparam logic [30:0] G_RESET = 31'd65536;

    typedef logic [30:0] t_cfg_word;

    typedef struct packed {
        logic [2:0]          op;
        logic signed [31:0]  x_value;
        logic signed [31:0]  y_value;
        logic signed [31:0]  z_value;
        logic signed [31:0]  mass_value;
        logic [15:0]         delta_t;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic signed [31:0]  vel_x;
        logic signed [31:0]  vel_y;
        logic signed [31:0]  vel_z;
        logic                removable;
        logic                overflow;
    } t_out_item;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_DIFF,
        S_SQ,
        S_KM,
        S_ROOT,
        S_RWAIT,
        S_FCAP,
        S_UGO,
        S_UWAIT,
        S_UCAP,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_ACC,
        S_IA,
        S_IV,
        S_IVD,
        S_IP,
        S_FIN
    } t_state;

    // Datapath commands.
    typedef enum logic [4:0] {
        C_NOP,
        C_LATCH,
        C_EXEC,
        C_DIFF,
        C_SQ,
        C_KM,
        C_ROOT,
        C_FCAP,
        C_UGO,
        C_UCAP,
        C_M0,
        C_M1,
        C_M2,
        C_M3,
        C_ACC,
        C_IA,
        C_IV,
        C_IVD,
        C_IP,
        C_OUT
    } t_dp_code;

    typedef struct packed {
        t_dp_code    code;
        logic [1:0]  lane;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0]  op;
        logic        skip;
        logic        div_busy;
        logic        sqrt_busy;
        logic        out_free;
    } t_dp_status;

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat_w(input logic signed [35:0] v);
        if (v > W_MAX) begin
            return W_MAX[31:0];
        end else if (v < W_MIN) begin
            return W_MIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic sat_ov(input logic signed [35:0] v);
        return (v > W_MAX) || (v < W_MIN);
    endfunction

endpackage

`default_nettype wire

// ===== src/gae_chan_if.sv =====
`default_nettype none

// Valid/ready channel with a typed payload.
interface gae_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/gae_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module gae_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [gae_pkg::DIV_NW-1:0]   i_num,
    input  wire logic [gae_pkg::DIV_DW-1:0]   i_den,
    output logic                              o_busy,
    output logic [gae_pkg::DIV_NW-1:0]        o_quot
);
    localparam int NW = gae_pkg::DIV_NW;
    localparam int DW = gae_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   trial;
    logic          fits;

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {r_rem, r_q[NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Dividend shifts out of the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[NW-2:0], fits};
            if (fits) begin
                r_rem <= DW'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DW-1:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

`default_nettype wire

// ===== src/gae_sqrt.sv =====
`default_nettype none

// Bit-pair integer square root of a 64-bit value.
module gae_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_busy,
    output logic [31:0]      o_root
);
    logic        r_busy;
    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
        end
    end

    // One result bit per cycle, testing bit pairs from the top down.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[31:0];
endmodule

`default_nettype wire

// ===== src/gae_ctrl.sv =====
`default_nettype none

// Sequencer that steps the datapath through each operation.
module gae_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire gae_pkg::t_dp_status i_status,
    output gae_pkg::t_dp_cmd         o_cmd
);
    gae_pkg::t_state r_state, n_state;
    logic [1:0]      r_lane, n_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gae_pkg::S_IDLE;
            r_lane  <= '0;
        end else begin
            r_state <= n_state;
            r_lane  <= n_lane;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        o_in_ready  = 1'b0;
        o_cmd.code  = gae_pkg::C_NOP;
        o_cmd.lane  = r_lane;
        unique case (r_state)
            gae_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.code = gae_pkg::C_LATCH;
                    n_state    = gae_pkg::S_DISP;
                    n_lane     = '0;
                end
            end
            gae_pkg::S_DISP: begin
                o_cmd.code = gae_pkg::C_EXEC;
                if (i_status.op == gae_pkg::OP_ACCUM) begin
                    n_state = gae_pkg::S_DIFF;
                end else if (i_status.op == gae_pkg::OP_INTEGRATE) begin
                    n_state = gae_pkg::S_IA;
                end else begin
                    n_state = gae_pkg::S_FIN;
                end
            end
            gae_pkg::S_DIFF: begin
                o_cmd.code = gae_pkg::C_DIFF;
                n_state    = gae_pkg::S_SQ;
            end
            gae_pkg::S_SQ: begin
                if (r_lane == 2'd0 && i_status.skip) begin
                    n_state = gae_pkg::S_FIN;
                end else begin
                    o_cmd.code = gae_pkg::C_SQ;
                    if (r_lane == 2'd2) begin
                        n_lane  = '0;
                        n_state = gae_pkg::S_KM;
                    end else begin
                        n_lane = r_lane + 2'd1;
                    end
                end
            end
            gae_pkg::S_KM: begin
                o_cmd.code = gae_pkg::C_KM;
                n_state    = gae_pkg::S_ROOT;
            end
            gae_pkg::S_ROOT: begin
                o_cmd.code = gae_pkg::C_ROOT;
                n_state    = gae_pkg::S_RWAIT;
            end
            gae_pkg::S_RWAIT: begin
                if (!i_status.div_busy && !i_status.sqrt_busy) begin
                    n_state = gae_pkg::S_FCAP;
                end
            end
            gae_pkg::S_FCAP: begin
                o_cmd.code = gae_pkg::C_FCAP;
                n_lane     = '0;
                n_state    = gae_pkg::S_UGO;
            end
            gae_pkg::S_UGO: begin
                o_cmd.code = gae_pkg::C_UGO;
                n_state    = gae_pkg::S_UWAIT;
            end
            gae_pkg::S_UWAIT: begin
                if (!i_status.div_busy) begin
                    n_state = gae_pkg::S_UCAP;
                end
            end
            gae_pkg::S_UCAP: begin
                o_cmd.code = gae_pkg::C_UCAP;
                n_state    = gae_pkg::S_M0;
            end
            gae_pkg::S_M0: begin
                o_cmd.code = gae_pkg::C_M0;
                n_state    = gae_pkg::S_M1;
            end
            gae_pkg::S_M1: begin
                o_cmd.code = gae_pkg::C_M1;
                n_state    = gae_pkg::S_M2;
            end
            gae_pkg::S_M2: begin
                o_cmd.code = gae_pkg::C_M2;
                n_state    = gae_pkg::S_M3;
            end
            gae_pkg::S_M3: begin
                o_cmd.code = gae_pkg::C_M3;
                n_state    = gae_pkg::S_ACC;
            end
            gae_pkg::S_ACC: begin
                o_cmd.code = gae_pkg::C_ACC;
                if (r_lane == 2'd2) begin
                    n_state = gae_pkg::S_FIN;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = gae_pkg::S_UGO;
                end
            end
            gae_pkg::S_IA: begin
                o_cmd.code = gae_pkg::C_IA;
                n_state    = gae_pkg::S_IV;
            end
            gae_pkg::S_IV: begin
                o_cmd.code = gae_pkg::C_IV;
                n_state    = gae_pkg::S_IVD;
            end
            gae_pkg::S_IVD: begin
                o_cmd.code = gae_pkg::C_IVD;
                n_state    = gae_pkg::S_IP;
            end
            gae_pkg::S_IP: begin
                o_cmd.code = gae_pkg::C_IP;
                if (r_lane == 2'd2) begin
                    n_state = gae_pkg::S_FIN;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = gae_pkg::S_IA;
                end
            end
            gae_pkg::S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.code = gae_pkg::C_OUT;
                    n_state    = gae_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gae_pkg::S_IDLE;
            end
        endcase
    end
endmodule

`default_nettype wire

// ===== src/gae_dp.sv =====
`default_nettype none

// Body state, arithmetic units and the result register.
module gae_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gae_pkg::t_dp_cmd    i_cmd,
    output gae_pkg::t_dp_status      o_status,
    input  wire gae_pkg::t_in_item   i_in_data,
    input  wire logic                i_cfg_valid,
    input  wire gae_pkg::t_cfg_word  i_cfg_data,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output gae_pkg::t_out_item       o_out_data
);
    localparam int NW = gae_pkg::DIV_NW;
    localparam int DW = gae_pkg::DIV_DW;

    // Body state.
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_acc [3];
    logic signed [31:0] r_mass;
    logic [30:0]        r_g;

    // Latched input beat.
    logic [2:0]         r_op;
    logic signed [31:0] r_vin [3];
    logic signed [31:0] r_min;
    logic [15:0]        r_dt;
    logic               r_ov;

    // Gravity working registers.
    logic [31:0]        r_ad [3];
    logic               r_dneg [3];
    logic [63:0]        r_prod;
    logic [65:0]        r_sum;
    logic [31:0]        r_s;
    logic [63:0]        r_f;
    logic [60:0]        r_u;
    logic [96:0]        r_mac;
    logic signed [48:0] r_iprod;

    logic               r_out_valid;
    gae_pkg::t_out_item r_out;

    logic [1:0]         lane;
    logic [31:0]        mul_a, mul_b;
    logic [31:0]        abs_m;
    logic               div_start, div_busy;
    logic [NW-1:0]      div_num, div_quot;
    logic [DW-1:0]      div_den;
    logic               sqrt_busy;
    logic [31:0]        sqrt_root;
    logic signed [31:0] ia;
    logic signed [16:0] dt_s;
    logic signed [32:0] ish;
    logic signed [35:0] isum;
    logic [66:0]        mag_full;
    logic               big;
    logic [33:0]        mag;
    logic signed [35:0] cval;
    logic signed [35:0] asum;
    logic               out_free;

    assign lane  = i_cmd.lane;
    assign abs_m = r_min[31] ? 32'(~r_min + 32'sd1) : r_min;

    // Shared 32x32 multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.code)
            gae_pkg::C_SQ: begin
                mul_a = r_ad[lane];
                mul_b = r_ad[lane];
            end
            gae_pkg::C_KM: begin
                mul_a = abs_m;
                mul_b = {1'b0, r_g};
            end
            gae_pkg::C_M0: begin
                mul_a = r_f[31:0];
                mul_b = r_u[31:0];
            end
            gae_pkg::C_M1: begin
                mul_a = r_f[63:32];
                mul_b = r_u[31:0];
            end
            gae_pkg::C_M2: begin
                mul_a = r_f[31:0];
                mul_b = {3'b0, r_u[60:32]};
            end
            default: begin
            end
        endcase
    end

    // Divider operands: force quotient first, then one unit-vector term per lane.
    assign div_start = (i_cmd.code == gae_pkg::C_ROOT) || (i_cmd.code == gae_pkg::C_UGO);
    always_comb begin
        if (i_cmd.code == gae_pkg::C_ROOT) begin
            div_num = {r_prod[61:0], 14'b0};
            div_den = r_sum[65:2] + gae_pkg::EPS_Q30;
        end else begin
            div_num = {15'b0, r_ad[lane], 29'b0};
            div_den = {32'b0, r_s};
        end
    end

    gae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    gae_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.code == gae_pkg::C_ROOT),
        .i_val   (r_sum[65:2]),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    // Time-step multiply for integration.
    assign ia   = (i_cmd.code == gae_pkg::C_IA) ? r_acc[lane] : r_vel[lane];
    assign dt_s = $signed({1'b0, r_dt});
    assign ish  = r_iprod[48:16];
    assign isum = (i_cmd.code == gae_pkg::C_IV) ? 36'(r_vel[lane]) + 36'(ish)
                                                : 36'(r_pos[lane]) + 36'(ish);

    // Scale the unit vector by the force and clamp oversized terms.
    assign mag_full = r_mac[96:30];
    assign big      = ((r_f[63:32] != '0) && (r_u[60:32] != '0))
                      || (mag_full > 67'h2_0000_0000);
    assign mag      = big ? 34'h2_0000_0000 : mag_full[33:0];
    assign cval     = (r_min[31] ^ r_dneg[lane]) ? -$signed({2'b0, mag})
                                                 : $signed({2'b0, mag});
    assign asum     = 36'(r_acc[lane]) + cval;

    // Free-running product registers.
    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_iprod <= ia * dt_s;
    end

    // Gravity working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.code)
            gae_pkg::C_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [32:0] d;
                    d = 33'(r_vin[i]) - 33'(r_pos[i]);
                    r_dneg[i] <= d[32];
                    r_ad[i]   <= d[32] ? 32'(-d) : d[31:0];
                end
            end
            gae_pkg::C_SQ: begin
                r_sum <= (lane == 2'd0) ? '0 : r_sum + {2'b0, r_prod};
            end
            gae_pkg::C_KM: begin
                r_sum <= r_sum + {2'b0, r_prod};
            end
            gae_pkg::C_FCAP: begin
                r_s <= (sqrt_root == '0) ? 32'd1 : sqrt_root;
                r_f <= (div_quot[NW-1:64] != '0) ? '1 : div_quot[63:0];
            end
            gae_pkg::C_UCAP: begin
                r_u <= div_quot[60:0];
            end
            gae_pkg::C_M1: begin
                r_mac <= {33'b0, r_prod};
            end
            gae_pkg::C_M2, gae_pkg::C_M3: begin
                r_mac <= r_mac + {1'b0, r_prod, 32'b0};
            end
            default: begin
            end
        endcase
    end

    // Input latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == gae_pkg::C_LATCH) begin
            r_op     <= i_in_data.op;
            r_vin[0] <= i_in_data.x_value;
            r_vin[1] <= i_in_data.y_value;
            r_vin[2] <= i_in_data.z_value;
            r_min    <= i_in_data.mass_value;
            r_dt     <= i_in_data.delta_t;
        end
    end

    // Body state, overflow flag and gravity constant.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_acc[i] <= '0;
            end
            r_mass <= 32'sd65536;
            r_g    <= gae_pkg::G_RESET;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_g <= i_cfg_data;
            end
            case (i_cmd.code)
                gae_pkg::C_LATCH: begin
                    r_ov <= 1'b0;
                end
                gae_pkg::C_EXEC: begin
                    case (r_op)
                        gae_pkg::OP_LOAD_POS: begin
                            for (int i = 0; i < 3; i++) begin
                                r_pos[i] <= r_vin[i];
                            end
                            r_mass <= r_min;
                        end
                        gae_pkg::OP_LOAD_VEL: begin
                            for (int i = 0; i < 3; i++) begin
                                r_vel[i] <= r_vin[i];
                            end
                        end
                        gae_pkg::OP_CLEAR_ACC: begin
                            for (int i = 0; i < 3; i++) begin
                                r_acc[i] <= '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                gae_pkg::C_ACC: begin
                    r_acc[lane] <= gae_pkg::sat_w(asum);
                    r_ov        <= r_ov | big | gae_pkg::sat_ov(asum);
                end
                gae_pkg::C_IV: begin
                    r_vel[lane] <= gae_pkg::sat_w(isum);
                    r_ov        <= r_ov | gae_pkg::sat_ov(isum);
                end
                gae_pkg::C_IP: begin
                    r_pos[lane] <= gae_pkg::sat_w(isum);
                    r_ov        <= r_ov | gae_pkg::sat_ov(isum);
                end
                default: begin
                end
            endcase
        end
    end

    // Result register.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.code == gae_pkg::C_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.code == gae_pkg::C_OUT) begin
            r_out.pos_x     <= r_pos[0];
            r_out.pos_y     <= r_pos[1];
            r_out.pos_z     <= r_pos[2];
            r_out.vel_x     <= r_vel[0];
            r_out.vel_y     <= r_vel[1];
            r_out.vel_z     <= r_vel[2];
            r_out.removable <= r_mass[31] || (r_mass == '0);
            r_out.overflow  <= r_ov;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status back to the controller.
    assign o_status.op        = r_op;
    assign o_status.skip      = r_mass[31] || (r_mass == '0)
                                || ((r_ad[0] == '0) && (r_ad[1] == '0) && (r_ad[2] == '0));
    assign o_status.div_busy  = div_busy;
    assign o_status.sqrt_busy = sqrt_busy;
    assign o_status.out_free  = out_free;
endmodule

`default_nettype wire

// ===== src/gravity_accumulate_euler_step_top.sv =====
// Channel  Dir  Payload                                      Beat taken when
// i_in     in   op, x/y/z_value, mass_value, delta_t         valid & ready
// o_out    out  pos_x/y/z, vel_x/y/z, removable, overflow    valid & ready
// i_cfg    in   gravity_constant (31 bits)                   valid & ready
//
// Loads, clears and unused opcodes are latched, executed, then sent to the output.
// Integrate does a multiply and a saturating add per term, per axis.
// Accumulate runs four 76-step divisions one after another on a single shared
// divider (force, then one per axis).
// Reset is synchronous, active low; it restores position, velocity and
// acceleration to zero, own mass to 1.0 and the gravity constant to 1.0.
// A stalled result stays in the output register; the next item is taken meanwhile.
`default_nettype none

module gravity_accumulate_euler_step_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gae_chan_if.sink   i_in,
    gae_chan_if.source o_out,
    gae_chan_if.sink   i_cfg
);
    gae_pkg::t_dp_cmd    cmd;
    gae_pkg::t_dp_status status;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    gae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gae_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );
endmodule

`default_nettype wire

// ===== src/gae_checker.sv =====
`default_nettype none

// Port-level checks for the gravity block.
module gae_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic [2:0]         i_in_op,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire gae_pkg::t_out_item i_out_data
);
    logic       in_acc, out_acc;
    logic [1:0] r_pend;
    logic [2:0] r_last_op;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Items taken but not yet delivered, and the op of the newest one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last_op <= i_in_op;
        end
    end

    // One item at a time: no beat is taken right after another.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input taken on two consecutive cycles");

    // Every result belongs to an accepted item.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 2'd0)
        else $error("result delivered with no item outstanding");

    // At most one finished and one working item.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many items outstanding");

    // Velocity loads and acceleration clears never saturate (checked with one item pending).
    a_no_ovf_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_pend == 2'd1
         && (r_last_op == gae_pkg::OP_LOAD_VEL || r_last_op == gae_pkg::OP_CLEAR_ACC))
        |-> !i_out_data.overflow)
        else $error("overflow reported on a load or clear");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");
endmodule

bind gravity_accumulate_euler_step_top gae_checker u_gae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.data.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
